[rtl/fdta_pkg.sv]
// Package for the fixed-point decimal to ASCII converter.
// Holds the field widths, character codes and sequencer state type.
// No dependencies.
package fdta_pkg;

  localparam int VALUE_W = 31;
  localparam int CHAR_W  = 6;
  localparam int NDIG    = 10;               // decimal digits of a 31-bit value
  localparam int POS_W   = $clog2(NDIG);
  localparam int CNT_W   = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CH_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] CH_DOT  = 6'd46;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_INT,
    ST_DOT,
    ST_FRAC
  } st_t;

endpackage

[rtl/fixed_decimal_to_ascii.sv]
// Top level of the fixed-point decimal to ASCII converter.
// Depends on fdta_pkg for widths, character codes and the state type.
//
// Each input item is an unsigned value in units of 10^-FRAC_DIGITS. The block
// writes it out as ASCII, one character per output item: the integer digits
// without leading zeros (at least one), then, only when the fraction is
// nonzero, a '.' and the fraction digits with trailing zeros dropped. The
// final character carries is_last. The binary value is turned into ten BCD
// digits by a shift-and-add-3 unit that handles one input bit per cycle. An
// item is accepted, converted and scanned, then its characters (1 to 11) go
// out one per cycle while the output side does not stall. in_ready is high
// only while the sequencer is idle; the last character of an item may still
// wait in the output register while the next item is taken.
module fixed_decimal_to_ascii
  import fdta_pkg::*;
#(
  parameter int FRAC_DIGITS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VALUE_W-1:0] value_micro,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] char_code,
  output logic              is_last
);

  localparam logic [POS_W-1:0] POS_FRAC = POS_W'(FRAC_DIGITS);
  localparam logic [POS_W-1:0] POS_TOP  = POS_W'(NDIG - 1);

  st_t state, state_next;

  logic [VALUE_W-1:0]  bin;
  logic [NDIG*4-1:0]   bcd;
  logic [NDIG*4-1:0]   bcd_adj;
  logic [CNT_W-1:0]    cnt;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    lsd;
  logic                frac_nz;

  logic [POS_W-1:0]    msd_scan;
  logic [POS_W-1:0]    lsd_scan;
  logic                frac_nz_scan;

  logic                accept;
  logic                slot_free;
  logic                load_out;
  logic [CHAR_W-1:0]   char_next;
  logic                last_next;
  logic [3:0]          cur_digit;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign cur_digit = bcd[pos*4 +: 4];

  // Add 3 to every BCD digit of five or more ahead of the shift.
  always_comb begin
    logic [3:0] d;
    d = '0;
    for (int i = 0; i < NDIG; i++) begin
      d = bcd[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  // Highest nonzero integer digit and lowest nonzero fraction digit.
  always_comb begin
    msd_scan     = POS_FRAC;
    lsd_scan     = '0;
    frac_nz_scan = 1'b0;
    for (int i = 0; i < NDIG; i++) begin
      if (i >= FRAC_DIGITS && bcd[i*4 +: 4] != 4'd0) begin
        msd_scan = POS_W'(i);
      end
    end
    for (int i = NDIG - 1; i >= 0; i--) begin
      if (i < FRAC_DIGITS && bcd[i*4 +: 4] != 4'd0) begin
        lsd_scan     = POS_W'(i);
        frac_nz_scan = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_CONV;
      ST_CONV: if (cnt == '0) state_next = ST_SCAN;
      ST_SCAN: state_next = ST_INT;
      ST_INT: begin
        if (slot_free && pos == POS_FRAC) begin
          state_next = frac_nz ? ST_DOT : ST_IDLE;
        end
      end
      ST_DOT:  if (slot_free) state_next = ST_FRAC;
      ST_FRAC: if (slot_free && pos == lsd) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    load_out  = 1'b0;
    char_next = CH_ZERO;
    last_next = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = !rst;
      ST_INT: begin
        load_out  = slot_free;
        char_next = CH_ZERO + {2'b00, cur_digit};
        last_next = (pos == POS_FRAC) && !frac_nz;
      end
      ST_DOT: begin
        load_out  = slot_free;
        char_next = CH_DOT;
      end
      ST_FRAC: begin
        load_out  = slot_free;
        char_next = CH_ZERO + {2'b00, cur_digit};
        last_next = (pos == lsd);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      char_code <= char_next;
      is_last   <= last_next;
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          bin <= value_micro;
          bcd <= '0;
          cnt <= CNT_W'(VALUE_W - 1);
        end
      end
      ST_CONV: begin
        bcd <= {bcd_adj[NDIG*4-2:0], bin[VALUE_W-1]};
        bin <= {bin[VALUE_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      ST_SCAN: begin
        pos     <= msd_scan;
        lsd     <= lsd_scan;
        frac_nz <= frac_nz_scan;
      end
      ST_INT: begin
        if (slot_free && pos != POS_FRAC) pos <= pos - 1'b1;
      end
      ST_DOT: begin
        if (slot_free) pos <= POS_FRAC - 1'b1;
      end
      ST_FRAC: begin
        if (slot_free && pos != lsd) pos <= pos - 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_CONV)
    else $error("accepted item did not start conversion");

  a_int_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_INT |-> (pos >= POS_FRAC && pos <= POS_TOP))
    else $error("integer digit pointer out of range");

  a_frac_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FRAC |-> (frac_nz && pos >= lsd && pos < POS_FRAC))
    else $error("fraction digit pointer out of range");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CH_DOT ||
                   (char_code >= CH_ZERO && char_code <= CH_ZERO + 6'd9)))
    else $error("illegal character in output register");

  a_no_emit_while_conv: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV || state == ST_SCAN) |-> !load_out)
    else $error("character emitted before conversion finished");

endmodule
